[hdl/cau_pkg.sv]
`default_nettype none
package cau_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int FRAC_BITS       = 8;
   localparam int MAG_BITS        = 2 * DATA_WIDTH;
   localparam int QUO_BITS        = DATA_WIDTH + 1;
   localparam int REM_BITS        = MAG_BITS + FRAC_BITS;
   localparam int CMP_BITS        = 3 * DATA_WIDTH + FRAC_BITS + 1;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (QUO_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [DATA_WIDTH:0]   sum_type;
   typedef logic signed [MAG_BITS-1:0]   prod_type;
   typedef logic signed [MAG_BITS:0]     val_type;
   typedef logic [MAG_BITS-1:0]          mag_type;
   typedef logic [REM_BITS-1:0]          rem_type;
   typedef logic [QUO_BITS-1:0]          quo_type;
   typedef logic [CMP_BITS-1:0]          cmp_type;

   // combined products, leaving the multiplier section
   typedef struct packed {
      logic    valid;
      op_type  op;
      sum_type sum_re;
      sum_type sum_im;
      logic    neg_re;
      logic    neg_im;
      mag_type mag_re;
      mag_type mag_im;
      mag_type den;
   } comb_type;

   // one slot of the divider pipeline; non-divide results ride along
   typedef struct packed {
      logic     valid;
      logic     is_div;
      logic     dz;
      logic     neg_re;
      logic     neg_im;
      logic     over_re;
      logic     over_im;
      rem_type  rem_re;
      rem_type  rem_im;
      mag_type  den;
      quo_type  q_re;
      quo_type  q_im;
      data_type res_re;
      data_type res_im;
      logic     ov;
   } div_type;

endpackage
`default_nettype wire

[hdl/cau_req_if.sv]
`default_nettype none
interface cau_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   cau_pkg::data_type   a_re;
   cau_pkg::data_type   a_im;
   cau_pkg::data_type   b_re;
   cau_pkg::data_type   b_im;

   modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface
`default_nettype wire

[hdl/cau_rsp_if.sv]
`default_nettype none
interface cau_rsp_if;
   logic                valid;
   logic                ready;
   cau_pkg::data_type   res_re;
   cau_pkg::data_type   res_im;
   logic                overflow;
   logic                div_zero;

   modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
   modport sink   (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface
`default_nettype wire

[hdl/cau_mult.sv]
`default_nettype none
module cau_mult (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   cau_req_if.sink            req,
   output cau_pkg::comb_type  comb
);

   // input register
   logic                 v1_ff;
   cau_pkg::op_type      op1_ff;
   cau_pkg::data_type    ar_ff, ai_ff, br_ff, bi_ff;

   // product register
   logic                 v2_ff;
   cau_pkg::op_type      op2_ff;
   cau_pkg::prod_type    p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   cau_pkg::sum_type     sum_re_in, sum_im_in, sum_re_ff, sum_im_ff;

   // combine register
   cau_pkg::comb_type    comb_in, comb_ff;
   cau_pkg::val_type     v_re, v_im;

   assign req.ready = adv & !reset;

   always_comb begin
      if (op1_ff == cau_pkg::OP_SUB) begin
         sum_re_in = cau_pkg::sum_type'(ar_ff) - cau_pkg::sum_type'(br_ff);
         sum_im_in = cau_pkg::sum_type'(ai_ff) - cau_pkg::sum_type'(bi_ff);
      end else begin
         sum_re_in = cau_pkg::sum_type'(ar_ff) + cau_pkg::sum_type'(br_ff);
         sum_im_in = cau_pkg::sum_type'(ai_ff) + cau_pkg::sum_type'(bi_ff);
      end
   end

   always_comb begin
      if (op2_ff == cau_pkg::OP_DIV) begin
         // a * conj(b)
         v_re = cau_pkg::val_type'(p_rr_ff) + cau_pkg::val_type'(p_ii_ff);
         v_im = cau_pkg::val_type'(p_ir_ff) - cau_pkg::val_type'(p_ri_ff);
      end else begin
         v_re = cau_pkg::val_type'(p_rr_ff) - cau_pkg::val_type'(p_ii_ff);
         v_im = cau_pkg::val_type'(p_ri_ff) + cau_pkg::val_type'(p_ir_ff);
      end
      comb_in.valid  = v2_ff;
      comb_in.op     = op2_ff;
      comb_in.sum_re = sum_re_ff;
      comb_in.sum_im = sum_im_ff;
      comb_in.neg_re = v_re[cau_pkg::MAG_BITS];
      comb_in.neg_im = v_im[cau_pkg::MAG_BITS];
      comb_in.mag_re = v_re[cau_pkg::MAG_BITS] ? cau_pkg::mag_type'(-v_re)
                                                : cau_pkg::mag_type'(v_re);
      comb_in.mag_im = v_im[cau_pkg::MAG_BITS] ? cau_pkg::mag_type'(-v_im)
                                                : cau_pkg::mag_type'(v_im);
      comb_in.den    = cau_pkg::mag_type'(sq_r_ff) + cau_pkg::mag_type'(sq_i_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         comb_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff     <= req.valid;
         op1_ff    <= cau_pkg::op_type'(req.req_type);
         ar_ff     <= req.a_re;
         ai_ff     <= req.a_im;
         br_ff     <= req.b_re;
         bi_ff     <= req.b_im;
         v2_ff     <= v1_ff;
         op2_ff    <= op1_ff;
         p_rr_ff   <= ar_ff * br_ff;
         p_ii_ff   <= ai_ff * bi_ff;
         p_ri_ff   <= ar_ff * bi_ff;
         p_ir_ff   <= ai_ff * br_ff;
         sq_r_ff   <= br_ff * br_ff;
         sq_i_ff   <= bi_ff * bi_ff;
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
         comb_ff   <= comb_in;
      end
   end

   assign comb = comb_ff;

endmodule
`default_nettype wire

[hdl/cau_div.sv]
`default_nettype none
module cau_div (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  cau_pkg::div_type  d_in,
   output cau_pkg::div_type  d_out
);

   cau_pkg::div_type stage_ff [cau_pkg::DIV_STAGES];
   cau_pkg::div_type stage_in [cau_pkg::DIV_STAGES];

   // restoring division, two quotient bits per stage, most significant first
   always_comb begin
      cau_pkg::div_type cur;
      cau_pkg::cmp_type dsh;
      int j;
      for (int s = 0; s < cau_pkg::DIV_STAGES; s++) begin
         cur = (s == 0) ? d_in : stage_ff[s-1];
         for (int k = 0; k < cau_pkg::STEPS_PER_STAGE; k++) begin
            j = cau_pkg::QUO_BITS - 1 - s * cau_pkg::STEPS_PER_STAGE - k;
            if (j >= 0) begin
               dsh = cau_pkg::cmp_type'(cur.den) << j;
               if (cau_pkg::cmp_type'(cur.rem_re) >= dsh) begin
                  cur.rem_re = cur.rem_re - cau_pkg::rem_type'(dsh);
                  cur.q_re   = cur.q_re | (cau_pkg::quo_type'(1) << j);
               end
               if (cau_pkg::cmp_type'(cur.rem_im) >= dsh) begin
                  cur.rem_im = cur.rem_im - cau_pkg::rem_type'(dsh);
                  cur.q_im   = cur.q_im | (cau_pkg::quo_type'(1) << j);
               end
            end
         end
         stage_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < cau_pkg::DIV_STAGES; s++) begin
            stage_ff[s].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int s = 0; s < cau_pkg::DIV_STAGES; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign d_out = stage_ff[cau_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

[hdl/complex_arithmetic_unit.sv]
// Complex add, subtract, multiply and divide on signed Q8.8 operands. One beat
// on req carries an opcode and operands a and b; one beat on rsp returns the
// saturated Q8.8 result with an overflow flag and a divide-by-zero flag (result
// forced to zero). The unit is a fixed pipeline of 3 + 1 + DIV_STAGES + 1 = 14
// register stages for every opcode, set by the divider, which retires two
// quotient bits per stage. A new beat is taken every cycle unless the output
// beat is held; results come back in order. Back-pressure on rsp freezes the
// whole pipeline, so req.ready drops only while the output beat is held and
// during reset.
`default_nettype none
module complex_arithmetic_unit (
   input  wire logic clock,
   input  wire logic reset,
   cau_req_if.sink   req,
   cau_rsp_if.source rsp
);

   localparam int W = cau_pkg::DATA_WIDTH;
   localparam cau_pkg::mag_type ROUND =
      cau_pkg::mag_type'((64'd1 << cau_pkg::FRAC_BITS) - 64'd1);
   localparam cau_pkg::mag_type PMAX = cau_pkg::mag_type'((64'd1 << (W - 1)) - 64'd1);
   localparam cau_pkg::mag_type NMAX = cau_pkg::mag_type'(64'd1 << (W - 1));

   // clamp a sign/magnitude value; returns {clamped, value}
   function automatic logic [W:0] sat_fn(input logic neg, input cau_pkg::mag_type mag);
      logic [W:0] r;
      if (neg) begin
         if (mag > NMAX) r = {1'b1, cau_pkg::data_type'(~NMAX + cau_pkg::mag_type'(1))};
         else            r = {1'b0, cau_pkg::data_type'(~mag + cau_pkg::mag_type'(1))};
      end else begin
         if (mag > PMAX) r = {1'b1, cau_pkg::data_type'(PMAX)};
         else            r = {1'b0, cau_pkg::data_type'(mag)};
      end
      return r;
   endfunction

   logic              adv;
   cau_pkg::comb_type comb;
   cau_pkg::div_type  pre_in, pre_ff, div_out;

   logic                rsp_valid_ff;
   cau_pkg::data_type   res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic                ov_ff, ov_in, dz_ff, dz_in;

   // advance everything whenever the output slot is free or being taken
   assign adv = !rsp_valid_ff || rsp.ready;

   cau_mult u_mult (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .req   (req),
      .comb  (comb)
   );

   // finish add/sub/mul here; set up the divider for divide
   always_comb begin
      logic [W:0]       s_re, s_im;
      cau_pkg::mag_type a_re, a_im, sh_re, sh_im;
      a_re  = comb.sum_re[W] ? cau_pkg::mag_type'(-comb.sum_re)
                             : cau_pkg::mag_type'(comb.sum_re);
      a_im  = comb.sum_im[W] ? cau_pkg::mag_type'(-comb.sum_im)
                             : cau_pkg::mag_type'(comb.sum_im);
      // floor shift of the product sums
      sh_re = (comb.neg_re ? comb.mag_re + ROUND : comb.mag_re) >> cau_pkg::FRAC_BITS;
      sh_im = (comb.neg_im ? comb.mag_im + ROUND : comb.mag_im) >> cau_pkg::FRAC_BITS;
      if (comb.op == cau_pkg::OP_MUL) begin
         s_re = sat_fn(comb.neg_re, sh_re);
         s_im = sat_fn(comb.neg_im, sh_im);
      end else begin
         s_re = sat_fn(comb.sum_re[W], a_re);
         s_im = sat_fn(comb.sum_im[W], a_im);
      end
      pre_in.valid   = comb.valid;
      pre_in.is_div  = (comb.op == cau_pkg::OP_DIV);
      pre_in.dz      = (comb.den == '0);
      pre_in.neg_re  = comb.neg_re;
      pre_in.neg_im  = comb.neg_im;
      // quotient would not fit the quotient register: saturate it
      pre_in.over_re = (cau_pkg::cmp_type'(comb.mag_re) << cau_pkg::FRAC_BITS) >=
                       (cau_pkg::cmp_type'(comb.den) << cau_pkg::QUO_BITS);
      pre_in.over_im = (cau_pkg::cmp_type'(comb.mag_im) << cau_pkg::FRAC_BITS) >=
                       (cau_pkg::cmp_type'(comb.den) << cau_pkg::QUO_BITS);
      pre_in.rem_re  = cau_pkg::rem_type'(comb.mag_re) << cau_pkg::FRAC_BITS;
      pre_in.rem_im  = cau_pkg::rem_type'(comb.mag_im) << cau_pkg::FRAC_BITS;
      pre_in.den     = comb.den;
      pre_in.q_re    = '0;
      pre_in.q_im    = '0;
      pre_in.res_re  = s_re[W-1:0];
      pre_in.res_im  = s_im[W-1:0];
      pre_in.ov      = s_re[W] | s_im[W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff.valid <= 1'b0;
      end else if (adv) begin
         pre_ff <= pre_in;
      end
   end

   cau_div u_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .d_in  (pre_ff),
      .d_out (div_out)
   );

   // output stage: sign and clamp the quotients, or pass the ready result
   always_comb begin
      logic [W:0]       s_re, s_im;
      cau_pkg::quo_type qs_re, qs_im;
      qs_re = div_out.over_re ? '1 : div_out.q_re;
      qs_im = div_out.over_im ? '1 : div_out.q_im;
      s_re  = sat_fn(div_out.neg_re && (qs_re != '0), cau_pkg::mag_type'(qs_re));
      s_im  = sat_fn(div_out.neg_im && (qs_im != '0), cau_pkg::mag_type'(qs_im));
      if (!div_out.is_div) begin
         res_re_in = div_out.res_re;
         res_im_in = div_out.res_im;
         ov_in     = div_out.ov;
         dz_in     = 1'b0;
      end else if (div_out.dz) begin
         res_re_in = '0;
         res_im_in = '0;
         ov_in     = 1'b0;
         dz_in     = 1'b1;
      end else begin
         res_re_in = s_re[W-1:0];
         res_im_in = s_im[W-1:0];
         ov_in     = s_re[W] | s_im[W];
         dz_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_out.valid;
      end
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         ov_ff     <= ov_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.res_re   = res_re_ff;
   assign rsp.res_im   = res_im_ff;
   assign rsp.overflow = ov_ff;
   assign rsp.div_zero = dz_ff;

   // a zero divisor always yields a clean zero beat
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dz_ff |-> res_re_ff == '0 && res_im_ff == '0 && !ov_ff)
      else $error("divide-by-zero beat carries nonzero data or overflow");

   // an overflow beat has at least one part pinned at a range limit
   a_ov_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ov_ff |->
         res_re_ff == cau_pkg::data_type'(PMAX) || res_im_ff == cau_pkg::data_type'(PMAX) ||
         res_re_ff == cau_pkg::data_type'(NMAX) || res_im_ff == cau_pkg::data_type'(NMAX))
      else $error("overflow flagged without a clamped part");

   // the pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !pre_ff.valid && !comb.valid)
      else $error("valid beat present right after reset");

endmodule
`default_nettype wire

[verif/tb_complex_arithmetic_unit.sv]
`default_nettype none
module tb_complex_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      cau_pkg::op_type   op;
      cau_pkg::data_type a_re;
      cau_pkg::data_type a_im;
      cau_pkg::data_type b_re;
      cau_pkg::data_type b_im;
   } operand_beat;

   typedef struct {
      cau_pkg::data_type res_re;
      cau_pkg::data_type res_im;
      logic              overflow;
      logic              div_zero;
   } result_beat;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cau_req_if req ();
   cau_rsp_if rsp ();

   complex_arithmetic_unit u_top (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   operand_beat pending_ops[$];
   result_beat  expected_results[$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          stim_done = 1'b0;
   // window of cycles with no idling on either side
   int          calm_start = 300;
   int          calm_stop = 700;

   // Clamp a wide signed value to the 16-bit range, raising the overflow flag.
   function automatic cau_pkg::data_type clamp_q88(input longint v, inout logic ov);
      if (v > 32767) begin
         ov = 1'b1;
         return 16'sh7fff;
      end
      if (v < -32768) begin
         ov = 1'b1;
         return 16'sh8000;
      end
      return cau_pkg::data_type'(v);
   endfunction

   // Truncating divide of (n << 8) by d, capped at plus or minus 131072.
   function automatic longint frac_quotient(input longint n, input longint d);
      longint q;
      q = (n <<< cau_pkg::FRAC_BITS) / d;
      if (q > 131072) q = 131072;
      if (q < -131072) q = -131072;
      return q;
   endfunction

   function automatic result_beat complex_result(input operand_beat b);
      result_beat r;
      longint ar, ai, br, bi, pr, pi, den;
      logic ov;
      ar = b.a_re; ai = b.a_im; br = b.b_re; bi = b.b_im;
      ov = 1'b0;
      r.div_zero = 1'b0;
      case (b.op)
         cau_pkg::OP_ADD: begin pr = ar + br; pi = ai + bi; end
         cau_pkg::OP_SUB: begin pr = ar - br; pi = ai - bi; end
         cau_pkg::OP_MUL: begin
            // arithmetic shift floors toward minus infinity
            pr = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
            pi = (ar * bi + ai * br) >>> cau_pkg::FRAC_BITS;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.div_zero = 1'b1;
               pr = 0; pi = 0;
            end else begin
               pr = frac_quotient(ar * br + ai * bi, den);
               pi = frac_quotient(ai * br - ar * bi, den);
            end
         end
      endcase
      r.res_re = clamp_q88(pr, ov);
      r.res_im = clamp_q88(pi, ov);
      r.overflow = ov;
      return r;
   endfunction

   function automatic cau_pkg::data_type rand_part();
      case ($urandom_range(0, 5))
         0: return cau_pkg::data_type'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
         1: return cau_pkg::data_type'($urandom_range(0, 1) ? 16'h0000 : 16'h0100);
         2: return cau_pkg::data_type'($signed($urandom_range(0, 1023)) - 512);
         default: return cau_pkg::data_type'($urandom);
      endcase
   endfunction

   task automatic push_op(input cau_pkg::op_type op, input int ar, input int ai,
                          input int br, input int bi);
      operand_beat b;
      b.op = op;
      b.a_re = cau_pkg::data_type'(ar); b.a_im = cau_pkg::data_type'(ai);
      b.b_re = cau_pkg::data_type'(br); b.b_im = cau_pkg::data_type'(bi);
      pending_ops.push_back(b);
   endtask

   // Fill the pending queue: directed corners first, then random beats.
   initial begin
      operand_beat b;
      push_op(cau_pkg::OP_ADD, 32767, -32768, 32767, -32768);
      push_op(cau_pkg::OP_ADD, 256, -256, 512, 768);
      push_op(cau_pkg::OP_SUB, -32768, 32767, 32767, -32768);
      push_op(cau_pkg::OP_SUB, 0, 0, -32768, -32768);
      push_op(cau_pkg::OP_MUL, 256, 0, -32768, 32767);
      push_op(cau_pkg::OP_MUL, -32768, -32768, -32768, -32768);
      push_op(cau_pkg::OP_MUL, 32767, 32767, 32767, -32768);
      push_op(cau_pkg::OP_MUL, -1, 0, 1, 0);
      push_op(cau_pkg::OP_MUL, -385, 129, 257, -3);
      push_op(cau_pkg::OP_DIV, 256, 256, 0, 0);
      push_op(cau_pkg::OP_DIV, -32768, -32768, 0, 0);
      push_op(cau_pkg::OP_DIV, 32767, 0, 1, 0);
      push_op(cau_pkg::OP_DIV, -32768, 32767, -1, 0);
      push_op(cau_pkg::OP_DIV, 256, 0, 768, 0);
      push_op(cau_pkg::OP_DIV, -256, 0, 768, 0);
      push_op(cau_pkg::OP_DIV, 1000, -77, 300, 400);
      push_op(cau_pkg::OP_DIV, -32768, -32768, -32768, -32768);
      push_op(cau_pkg::OP_DIV, 1, 1, 32767, -32768);
      repeat (1200) begin
         b.op = cau_pkg::op_type'($urandom_range(0, 3));
         b.a_re = rand_part(); b.a_im = rand_part();
         b.b_re = rand_part(); b.b_im = rand_part();
         if (b.op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
            b.b_re = '0; b.b_im = '0;
         end
         pending_ops.push_back(b);
      end
      stim_done = 1'b1;
   end

   // Driver: present the next pending beat, idle at random outside the calm window.
   always @(posedge clock) begin
      operand_beat b;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         // the current beat, if any, is taken at this edge
         if (req.valid)
            expected_results.push_back(complex_result(pending_ops.pop_front()));
         if (pending_ops.size() != 0 &&
             ((cycles > calm_start && cycles < calm_stop) ||
              $urandom_range(0, 99) >= 26)) begin
            b = pending_ops[0];
            req.valid <= 1'b1;
            req.req_type <= b.op;
            req.a_re <= b.a_re; req.a_im <= b.a_im;
            req.b_re <= b.b_re; req.b_im <= b.b_im;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each result beat with the oldest expectation; stall at random.
   always @(posedge clock) begin
      result_beat want;
      cycles <= cycles + 1;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected result beat re=%0d im=%0d", rsp.res_re, rsp.res_im);
            end else begin
               want = expected_results.pop_front();
               if (rsp.res_re !== want.res_re || rsp.res_im !== want.res_im ||
                   rsp.overflow !== want.overflow || rsp.div_zero !== want.div_zero) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"mismatch: want re=%0d im=%0d ov=%b dz=%b, ",
                               "got re=%0d im=%0d ov=%b dz=%b"},
                              want.res_re, want.res_im, want.overflow, want.div_zero,
                              rsp.res_re, rsp.res_im, rsp.overflow, rsp.div_zero);
               end
            end
         end
         rsp.ready <= (cycles > calm_start && cycles < calm_stop) ||
                      $urandom_range(0, 99) >= 26;
      end
   end

   // Hold reset, then wait for the drain and report.
   initial begin
      req.valid = 1'b0;
      req.req_type = cau_pkg::OP_ADD;
      req.a_re = '0; req.a_im = '0; req.b_re = '0; req.b_im = '0;
      rsp.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && pending_ops.size() == 0 && !req.valid &&
            expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: drop out on a hang once the cycle count reaches the limit.
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end
endmodule
`default_nettype wire

[sim.f]
hdl/cau_pkg.sv
hdl/cau_req_if.sv
hdl/cau_rsp_if.sv
hdl/cau_mult.sv
hdl/cau_div.sv
hdl/complex_arithmetic_unit.sv
verif/tb_complex_arithmetic_unit.sv
